// ===== design/b32d_pkg.sv =====
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and character lookups for the Base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int MAX_BYTES = 64;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 7;
    localparam int ACC_W   = 12;
    localparam int HELD_W  = 4;
    localparam int SYM_W   = 5;
    localparam int BYTE_W  = 8;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(64);
    localparam logic [COUNT_W-1:0] LIMIT_MAX   = COUNT_W'(MAX_BYTES);
    localparam logic [HELD_W-1:0]  SYM_BITS    = HELD_W'(5);
    localparam logic [HELD_W-1:0]  BYTE_BITS   = HELD_W'(8);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_W-1:0] DIGIT_OFS = 8'h1a;  // '2' maps to 26

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [HELD_W-1:0]  held;
        logic [COUNT_W-1:0] count;
        status_t            err;
    } dec_state_t;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  byte_value;
        logic               done_res;
        status_t            status;
        logic [COUNT_W-1:0] byte_count;
    } dec_result_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] value;
    } sym_t;

    function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] c);
        sym_t             s;
        logic [CHAR_W-1:0] d;
        s = '0;
        d = '0;
        if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA;
            s.valid = 1'b1;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA;
            s.valid = 1'b1;
        end else if (c >= CH_TWO && c <= CH_SEVEN) begin
            d = c - CH_TWO + DIGIT_OFS;
            s.valid = 1'b1;
        end
        s.value = d[SYM_W-1:0];
        return s;
    endfunction

    function automatic logic is_skipped(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_LF) || (c == CH_DASH) || (c == CH_EQ);
    endfunction

endpackage

// ===== design/b32d_step.sv =====
// ----------------------------------------------------------------------------
// b32d_step
// Next-state and result logic for one character of the Base32 decoder.
// ----------------------------------------------------------------------------
module b32d_step
    import b32d_pkg::*;
(
    input  dec_state_t         state_cur,
    input  logic [CHAR_W-1:0]  in_char,
    input  logic               first_of_string,
    input  logic [COUNT_W-1:0] output_limit,
    output dec_state_t         state_next,
    output dec_result_t        result
);

    dec_state_t         base;
    sym_t               sym;
    logic [COUNT_W-1:0] limit;
    logic [ACC_W-1:0]   acc_shift;
    logic [HELD_W-1:0]  held_add;
    logic [HELD_W-1:0]  held_sub;
    logic [ACC_W-1:0]   acc_out;

    assign sym       = sym_lookup(in_char);
    assign limit     = (output_limit < LIMIT_MAX) ? output_limit : LIMIT_MAX;
    assign base      = first_of_string ? dec_state_t'('0) : state_cur;
    assign acc_shift = {base.acc[ACC_W-SYM_W-1:0], sym.value};
    assign held_add  = base.held + SYM_BITS;
    assign held_sub  = held_add - BYTE_BITS;
    assign acc_out   = acc_shift >> held_sub;

    always_comb begin
        state_next        = base;
        result.byte_valid = 1'b0;
        result.byte_value = '0;
        result.done_res   = (in_char == CH_NUL);
        if (in_char != CH_NUL && base.err == STATUS_OK && !is_skipped(in_char)) begin
            if (!sym.valid) begin
                state_next.err = STATUS_INVALID;
            end else begin
                state_next.acc  = acc_shift;
                state_next.held = held_add;
                if (held_add >= BYTE_BITS) begin
                    state_next.held = held_sub;
                    if (base.count >= limit) begin
                        state_next.err = STATUS_OVERFLOW;
                    end else begin
                        result.byte_valid = 1'b1;
                        result.byte_value = acc_out[BYTE_W-1:0];
                        state_next.count  = base.count + COUNT_W'(1);
                    end
                end
            end
        end
        result.status     = state_next.err;
        result.byte_count = state_next.count;
    end

endmodule

// ===== design/base32_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// base32_stream_decoder_core
// Streaming Base32 decoder: one character in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   Characters arrive on the s_ channel, s_tdata[7:0] the character and
//   s_tuser[0] the first-of-string flag that clears the decoder before the
//   character. Every accepted character yields exactly one result on the m_
//   channel: decoded byte and running byte count in m_tdata, byte-valid and
//   sticky status in m_tuser, and m_tlast marking the terminating zero.
//   Write the output limit via cfg_wr_en/cfg_wr_data only while idle (unchecked).
// Timing:
//   The result of a character is presented the cycle after its transfer;
//   one character per cycle is sustained while m_tready is high. The decoder
//   state and the result register update in the same cycle, set by the
//   per-character lookup, shift and limit compare.
// Reset and stall:
//   aresetn clears the decoder state and the output valid and sets the limit
//   to 64. While a result waits with m_tready low, the result register holds
//   and s_tready drops; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module base32_stream_decoder_core
    import b32d_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_char
    input  logic [0:0]   s_tuser,   // [0] first_of_string
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [7:0] byte_value, [14:8] byte_count, [15] zero
    output logic [2:0]   m_tuser,   // [0] byte_valid, [2:1] status
    output logic         m_tlast,   // done_res
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data
);

    dec_state_t         state_reg;
    dec_state_t         state_next;
    dec_result_t        res_next;
    dec_result_t        res_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic               s_xfer;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    b32d_step u_step (
        .state_cur       (state_reg),
        .in_char         (s_tdata),
        .first_of_string (s_tuser[0]),
        .output_limit    (limit_reg),
        .state_next      (state_next),
        .result          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (s_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg.byte_count, res_reg.byte_value};
    assign m_tuser  = {res_reg.status, res_reg.byte_valid};
    assign m_tlast  = res_reg.done_res;

endmodule

// ===== design/b32d_checker.sv =====
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks for the Base32 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
            $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    a_byte_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == 2'd0 && !m_tlast)
        else $error("byte emitted with error or terminator");

    a_no_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("byte value nonzero without byte_valid");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:8] <= 7'd64 && m_tuser[2:1] != 2'd3)
        else $error("byte count or status out of range");

endmodule

bind base32_stream_decoder_core b32d_checker u_b32d_checker (.*);

// ===== tb/sv/base32_stream_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// base32_stream_decoder_core_tb
// Self-checking bench for the streaming Base32 decoder. A driver feeds
// characters from a queue, a predictor tracks the decoder state for every
// accepted transfer, and a monitor compares each result field by field.
// The output limit is swept across its extremes between drained phases.
// The phases cycle through four idle and stall patterns on the two channels.
// ----------------------------------------------------------------------------
module base32_stream_decoder_core_tb;
    import b32d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              first;
        logic              pause;
    } char_item_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata     = '0;   // [7:0] in_char
    logic [0:0]   s_tuser     = '0;   // [0] first_of_string
    logic         m_tvalid;
    logic         m_tready    = 1'b0;
    logic [15:0]  m_tdata;            // [7:0] byte_value, [14:8] byte_count, [15] zero
    logic [2:0]   m_tuser;            // [0] byte_valid, [2:1] status
    logic         m_tlast;
    logic         cfg_wr_en   = 1'b0;
    logic [6:0]   cfg_wr_data = '0;

    char_item_t  char_q[$];
    dec_result_t decoded_q[$];
    char_item_t  next_char;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_count     = 0;
    int          string_count   = 0;

    logic [ACC_W-1:0]   acc_bits   = '0;
    logic [HELD_W-1:0]  held_bits  = '0;
    logic [COUNT_W-1:0] byte_total = '0;
    status_t            sticky_err = STATUS_OK;
    logic [COUNT_W-1:0] out_limit  = LIMIT_RESET;

    base32_stream_decoder_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic dec_result_t decode_char(input logic [CHAR_W-1:0] c,
                                                input logic first);
        dec_result_t        r;
        logic [COUNT_W-1:0] lim;
        logic               sym_ok;
        logic               skip;
        logic [SYM_W-1:0]   sym;
        r      = '0;
        lim    = (out_limit < LIMIT_MAX) ? out_limit : LIMIT_MAX;
        sym_ok = 1'b1;
        sym    = '0;
        skip   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                 (c == CH_LF) || (c == CH_DASH) || (c == CH_EQ);
        if (c >= CH_UA && c <= CH_UZ) begin
            sym = SYM_W'(c - CH_UA);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            sym = SYM_W'(c - CH_LA);
        end else if (c >= CH_TWO && c <= CH_SEVEN) begin
            sym = SYM_W'(c - CH_TWO + 8'd26);
        end else begin
            sym_ok = 1'b0;
        end
        if (first) begin
            acc_bits   = '0;
            held_bits  = '0;
            byte_total = '0;
            sticky_err = STATUS_OK;
        end
        if (c == CH_NUL) begin
            r.done_res = 1'b1;
        end else if (sticky_err == STATUS_OK && !skip) begin
            if (!sym_ok) begin
                sticky_err = STATUS_INVALID;
            end else begin
                acc_bits  = {acc_bits[ACC_W-SYM_W-1:0], sym};
                held_bits = held_bits + SYM_BITS;
                if (held_bits >= BYTE_BITS) begin
                    held_bits = held_bits - BYTE_BITS;
                    if (byte_total >= lim) begin
                        sticky_err = STATUS_OVERFLOW;
                    end else begin
                        r.byte_valid = 1'b1;
                        r.byte_value = BYTE_W'(acc_bits >> held_bits);
                        byte_total   = byte_total + 1'b1;
                    end
                end
            end
        end
        r.status     = sticky_err;
        r.byte_count = byte_total;
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] symbol_char(input int idx, input logic lower);
        if (idx >= 26) begin
            return CH_TWO + CHAR_W'(idx - 26);
        end
        return (lower ? CH_LA : CH_UA) + CHAR_W'(idx);
    endfunction

    function automatic logic [CHAR_W-1:0] skip_char(input int sel);
        case (sel)
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            4: return CH_DASH;
            default: return CH_EQ;
        endcase
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic first,
                             input logic pause = 1'b0);
        char_item_t it;
        it.ch    = c;
        it.first = first;
        it.pause = pause;
        char_q.push_back(it);
    endtask

    task automatic add_directed();
        push_char(CH_UA, 1'b1);
        push_char(CH_UZ, 1'b0);
        push_char(CH_LA, 1'b0);
        push_char(CH_LZ, 1'b0);
        push_char(CH_TWO, 1'b0);
        push_char(CH_SEVEN, 1'b0);
        for (int i = 0; i < 6; i++) begin
            push_char(skip_char(i), 1'b0);
        end
        push_char(CH_NUL, 1'b0);
        push_char(CH_UA + 8'd1, 1'b0);
        push_char(CH_TWO - 8'd1, 1'b0);
        push_char(CH_UA + 8'd2, 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char(CH_NUL, 1'b1);
        push_char(CH_UA - 8'd1, 1'b1);
        push_char(CH_UZ + 8'd1, 1'b1);
        push_char(CH_LA - 8'd1, 1'b1);
        push_char(CH_LZ + 8'd1, 1'b1);
        push_char(CH_SEVEN + 8'd1, 1'b1);
        push_char(8'hff, 1'b1);
        push_char(8'h80, 1'b1);
        push_char(CH_SEVEN, 1'b1, 1'b1);
        push_char(CH_SEVEN, 1'b0);
    endtask

    task automatic add_random_string();
        int n;
        int r;
        logic first;
        logic [CHAR_W-1:0] c;
        n = ($urandom_range(19) == 0) ? $urandom_range(140, 105) : $urandom_range(24, 1);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 84) begin
                c = symbol_char($urandom_range(31), 1'($urandom_range(1)));
            end else if (r < 92) begin
                c = skip_char($urandom_range(5));
            end else begin
                c = CHAR_W'($urandom_range(255));
            end
            first = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            push_char(c, first, (i == 0) && (string_count % 4 == 2));
        end
        if ($urandom_range(6) != 0) begin
            push_char(CH_NUL, 1'b0);
        end
        string_count++;
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || s_tvalid || decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        out_limit = v;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decoded_q.push_back(decode_char(s_tdata, s_tuser[0]));
            end
            if (!s_tvalid || s_tready) begin
                if (char_q.size() != 0 && !(char_q[0].pause && decoded_q.size() != 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    next_char = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_char.ch;
                    s_tuser  <= next_char.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        dec_result_t want;
        dec_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_valid = m_tuser[0];
            got.byte_value = m_tdata[7:0];
            got.done_res   = m_tlast;
            got.status     = status_t'(m_tuser[2:1]);
            got.byte_count = m_tdata[14:8];
            if (decoded_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected result tdata=%h tuser=%h tlast=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                end
            end else begin
                want = decoded_q.pop_front();
                if (got !== want || m_tdata[15] !== 1'b0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch valid %b/%b byte %h/%h done %b/%b",
                                 $realtime, want.byte_valid, got.byte_valid,
                                 want.byte_value, got.byte_value,
                                 want.done_res, got.done_res);
                        $display("    status %0d/%0d count %0d/%0d pad %b (expected/actual)",
                                 want.status, got.status, want.byte_count,
                                 got.byte_count, m_tdata[15]);
                    end
                end
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] lim;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        add_directed();
        wait_drained();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: lim = '0;
                1: lim = COUNT_W'(1);
                2: lim = COUNT_W'(5);
                3: lim = '1;
                4: lim = LIMIT_MAX;
                default: lim = COUNT_W'($urandom_range(127));
            endcase
            write_limit(lim);
            case (p % 4)
                0: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                1: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                2: begin send_idle_pct = 27; recv_stall_pct = 27; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            push_char(CH_SEVEN, 1'b1);
            push_char(CH_UA, 1'b0);
            while (char_q.size() < 100) begin
                add_random_string();
            end
            wait_drained();
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
